/* hdl/drgb_pkg.sv */
// types and constants shared by the decimal rgb triplet parser
// no dependencies; compile first

package drgb_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned ValueWidth  = 10;
  localparam int unsigned CountWidth  = 3;
  localparam int unsigned FieldWidth  = 2;
  localparam int unsigned NumFields   = 3;
  localparam int unsigned RgbWidth    = 24;
  localparam int unsigned KindWidth   = 3;

  // character codes
  localparam logic [CharWidth-1:0] CH_NUL   = 8'h00;
  localparam logic [CharWidth-1:0] CH_TAB   = 8'h09;
  localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
  localparam logic [CharWidth-1:0] CH_COMMA = 8'h2c;
  localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;

  // field index once all three values have ended, also "no long value"
  localparam logic [FieldWidth-1:0] FIELD_DONE = 2'd3;

  // digit counter limits
  localparam logic [CountWidth-1:0] DIGITS_ADDED = 3'd3;
  localparam logic [CountWidth-1:0] DIGITS_SAT   = 3'd4;

  localparam logic [ValueWidth-1:0] CHANNEL_MAX = 10'd255;

  typedef enum logic [KindWidth-1:0] {
    ERR_NONE    = 3'd0,
    ERR_LONG    = 3'd1,
    ERR_CHAR    = 3'd2,
    ERR_MISSING = 3'd3,
    ERR_RANGE   = 3'd4
  } error_kind_t;

  typedef struct packed {
    logic [FieldWidth-1:0] field_index;
    logic                  in_digits;
    logic                  comma_taken;
    logic                  at_line_start;
    logic [CountWidth-1:0] digit_count;
    logic [FieldWidth-1:0] first_long_field;
    logic                  bad_seen;
    logic [CharWidth-1:0]  bad_char;
    logic [NumFields-1:0]  missing_mask;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    field_index:      2'd0,
    in_digits:        1'b0,
    comma_taken:      1'b0,
    at_line_start:    1'b1,
    digit_count:      3'd0,
    first_long_field: FIELD_DONE,
    bad_seen:         1'b0,
    bad_char:         8'h00,
    missing_mask:     3'b000
  };

endpackage

/* hdl/drgb_char_if.sv */
// character channel of the decimal rgb triplet parser
// depends on drgb_pkg

interface drgb_char_if;
  logic                           valid;
  logic                           ready;
  logic [drgb_pkg::CharWidth-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

/* hdl/drgb_result_if.sv */
// result channel of the decimal rgb triplet parser
// depends on drgb_pkg

interface drgb_result_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [drgb_pkg::RgbWidth-1:0]   rgb;
  logic [drgb_pkg::KindWidth-1:0]  error_kind;
  logic [drgb_pkg::ValueWidth-1:0] error_detail;

  modport source (output valid, output ok, output rgb, output error_kind,
                  output error_detail, input ready);
  modport sink   (input valid, input ok, input rgb, input error_kind,
                  input error_detail, output ready);
endinterface

/* hdl/decimal_rgb_triplet_parser.sv */
// decimal rgb triplet parser, top level
// depends on drgb_pkg, drgb_char_if, drgb_result_if

// Takes a text line one character per transaction on chars and, when the
// line-ending NUL character arrives, delivers one transaction on result:
// either ok with the packed colour red<<16 | green<<8 | blue, or an error
// kind and detail (long value, bad or trailing character, missing value,
// value over 255, in that priority). Characters other than NUL give no
// result. The block takes one character every clock cycle, except for the
// stall named below, with no gaps between lines; each character passes an
// input register and one step of parse logic that updates the line state,
// and a NUL in the input register loads the result register. The only
// stall is a NUL waiting on a result register that is still full.

module decimal_rgb_triplet_parser (
  input logic           clk,
  input logic           rst,
  drgb_char_if.sink     chars,
  drgb_result_if.source result
);

  // input register
  logic                           s1_valid;
  logic [drgb_pkg::CharWidth-1:0] s1_ch;
  logic                           s1_nul;
  logic                           s1_go;

  // line state
  drgb_pkg::parse_state_t          st;
  drgb_pkg::parse_state_t          st_next;
  logic [drgb_pkg::ValueWidth-1:0] chan     [drgb_pkg::NumFields];
  logic [drgb_pkg::ValueWidth-1:0] chan_next[drgb_pkg::NumFields];

  // result register
  logic                            res_valid;
  logic                            res_ok;
  logic [drgb_pkg::RgbWidth-1:0]   res_rgb;
  drgb_pkg::error_kind_t           res_kind;
  logic [drgb_pkg::ValueWidth-1:0] res_detail;

  // values computed for the line as it ends
  drgb_pkg::parse_state_t          fin;
  logic                            fin_ok;
  logic [drgb_pkg::RgbWidth-1:0]   fin_rgb;
  drgb_pkg::error_kind_t           fin_kind;
  logic [drgb_pkg::ValueWidth-1:0] fin_detail;

  logic is_blank;
  logic is_digit;
  logic [drgb_pkg::ValueWidth-1:0] digit_val;

  // a NUL may only move on when the result register can take it
  assign s1_nul      = (s1_ch == drgb_pkg::CH_NUL);
  assign s1_go       = s1_valid && (!s1_nul || !res_valid || result.ready);
  assign chars.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s1_ch <= chars.ch;
    end
  end

  assign is_blank  = (s1_ch == drgb_pkg::CH_SPACE) || (s1_ch == drgb_pkg::CH_TAB);
  assign is_digit  = (s1_ch >= drgb_pkg::CH_ZERO) && (s1_ch <= drgb_pkg::CH_NINE);
  assign digit_val = {2'b00, s1_ch - drgb_pkg::CH_ZERO};

  // one character step: each pass either takes the character or closes the
  // current value, so three passes cover every case
  always_comb begin
    logic consumed;
    logic ends_value;
    logic good;
    fin      = st;
    consumed = 1'b0;
    for (int j = 0; j < drgb_pkg::NumFields; j++) begin
      chan_next[j] = chan[j];
    end
    for (int i = 0; i < drgb_pkg::NumFields; i++) begin
      ends_value = 1'b0;
      good       = 1'b0;
      if (!consumed && fin.field_index != drgb_pkg::FIELD_DONE) begin
        if (!fin.in_digits) begin
          if (is_blank) begin
            consumed = 1'b1;
          end else if (!fin.comma_taken && s1_ch == drgb_pkg::CH_COMMA &&
                       !fin.at_line_start) begin
            fin.comma_taken = 1'b1;
            consumed        = 1'b1;
          end else if (is_digit) begin
            fin.in_digits   = 1'b1;
            fin.digit_count = 3'd1;
            for (int j = 0; j < drgb_pkg::NumFields; j++) begin
              if (fin.field_index == j[drgb_pkg::FieldWidth-1:0]) begin
                chan_next[j] = digit_val;
              end
            end
            consumed = 1'b1;
          end else begin
            ends_value = 1'b1;
          end
        end else begin
          if (is_digit) begin
            // digits past the third are counted but not added
            for (int j = 0; j < drgb_pkg::NumFields; j++) begin
              if (fin.field_index == j[drgb_pkg::FieldWidth-1:0] &&
                  fin.digit_count < drgb_pkg::DIGITS_ADDED) begin
                chan_next[j] = (chan_next[j] << 3) + (chan_next[j] << 1) + digit_val;
              end
            end
            if (fin.digit_count < drgb_pkg::DIGITS_SAT) begin
              fin.digit_count = fin.digit_count + 3'd1;
            end
            consumed = 1'b1;
          end else begin
            ends_value = 1'b1;
            good = (s1_ch == drgb_pkg::CH_NUL) || (s1_ch == drgb_pkg::CH_COMMA) || is_blank;
          end
        end
        if (ends_value) begin
          if (good) begin
            if (fin.digit_count > drgb_pkg::DIGITS_ADDED &&
                fin.first_long_field == drgb_pkg::FIELD_DONE) begin
              fin.first_long_field = fin.field_index;
            end
          end else begin
            for (int j = 0; j < drgb_pkg::NumFields; j++) begin
              if (fin.field_index == j[drgb_pkg::FieldWidth-1:0]) begin
                fin.missing_mask[j] = 1'b1;
              end
            end
          end
          fin.field_index = fin.field_index + 2'd1;
          fin.in_digits   = 1'b0;
          fin.comma_taken = 1'b0;
          fin.digit_count = 3'd0;
        end
      end
    end
    // first character left over once all values are closed
    if (!consumed && !s1_nul && !fin.bad_seen) begin
      fin.bad_seen = 1'b1;
      fin.bad_char = s1_ch;
    end
    fin.at_line_start = 1'b0;
  end

  // result selection in priority order
  always_comb begin
    fin_ok     = 1'b0;
    fin_rgb    = '0;
    fin_kind   = drgb_pkg::ERR_NONE;
    fin_detail = '0;
    if (fin.first_long_field != drgb_pkg::FIELD_DONE) begin
      fin_kind   = drgb_pkg::ERR_LONG;
      fin_detail = {8'd0, fin.first_long_field};
    end else if (fin.bad_seen) begin
      fin_kind   = drgb_pkg::ERR_CHAR;
      fin_detail = {2'b00, fin.bad_char};
    end else if (fin.missing_mask != 3'b000) begin
      fin_kind   = drgb_pkg::ERR_MISSING;
      fin_detail = fin.missing_mask[0] ? 10'd0 : (fin.missing_mask[1] ? 10'd1 : 10'd2);
    end else if (chan_next[0] > drgb_pkg::CHANNEL_MAX) begin
      fin_kind   = drgb_pkg::ERR_RANGE;
      fin_detail = chan_next[0];
    end else if (chan_next[1] > drgb_pkg::CHANNEL_MAX) begin
      fin_kind   = drgb_pkg::ERR_RANGE;
      fin_detail = chan_next[1];
    end else if (chan_next[2] > drgb_pkg::CHANNEL_MAX) begin
      fin_kind   = drgb_pkg::ERR_RANGE;
      fin_detail = chan_next[2];
    end else begin
      fin_ok  = 1'b1;
      fin_rgb = {chan_next[0][7:0], chan_next[1][7:0], chan_next[2][7:0]};
    end
  end

  // line state returns to reset after the NUL
  assign st_next = s1_nul ? drgb_pkg::PARSE_RESET : fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= drgb_pkg::PARSE_RESET;
      for (int j = 0; j < drgb_pkg::NumFields; j++) begin
        chan[j] <= '0;
      end
    end else if (s1_go) begin
      st <= st_next;
      for (int j = 0; j < drgb_pkg::NumFields; j++) begin
        chan[j] <= s1_nul ? '0 : chan_next[j];
      end
    end
  end

  // result register, refilled in the same cycle it is drained
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_nul) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (s1_go && s1_nul) begin
      res_ok     <= fin_ok;
      res_rgb    <= fin_rgb;
      res_kind   <= fin_kind;
      res_detail <= fin_detail;
    end
  end

  assign result.valid        = res_valid;
  assign result.ok           = res_ok;
  assign result.rgb          = res_rgb;
  assign result.error_kind   = res_kind;
  assign result.error_detail = res_detail;

`ifndef ASSERT_OFF
  a_ok_no_error: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ok |-> res_kind == drgb_pkg::ERR_NONE)
    else $error("ok result carries an error kind");

  a_error_no_rgb: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ok |-> res_rgb == '0 && res_kind != drgb_pkg::ERR_NONE)
    else $error("error result carries a colour or no kind");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_nul |=> st.field_index == 2'd0 && st.at_line_start &&
                        !st.bad_seen && st.missing_mask == 3'b000)
    else $error("line state not cleared after line end");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    st.field_index == drgb_pkg::FIELD_DONE |-> !st.in_digits && st.digit_count == 3'd0)
    else $error("value still open after all fields ended");

  a_nul_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_nul && res_valid && !result.ready |=> s1_valid && s1_nul)
    else $error("line end lost while result stalled");
`endif

endmodule

/* tb/tb_decimal_rgb_triplet_parser.sv */
// testbench for the decimal rgb triplet parser: drives colour lines one character
// per transaction and checks each line result against a built-in line predictor
// depends on drgb_pkg, drgb_char_if, drgb_result_if and decimal_rgb_triplet_parser

module tb_decimal_rgb_triplet_parser;

  // one line result as the block reports it
  typedef struct packed {
    logic                            ok;
    logic [drgb_pkg::RgbWidth-1:0]   rgb;
    drgb_pkg::error_kind_t           kind;
    logic [drgb_pkg::ValueWidth-1:0] detail;
  } colour_result_t;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RESET_CYCLES  = 10;
  // leave some margin at the end
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  drgb_char_if   chars();
  drgb_result_if result();

  decimal_rgb_triplet_parser dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .result(result)
  );

  always #10 clk = ~clk;

  // run bookkeeping
  int unsigned cycle_count   = 0;
  int unsigned errors        = 0;
  int unsigned chars_sent    = 0;
  int unsigned lines_checked = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  colour_result_t                   expected_colours[$];
  logic [drgb_pkg::CharWidth-1:0]   line_text[$];

  // line predictor state
  logic [drgb_pkg::FieldWidth-1:0]  pos_field;
  logic                             in_number;
  logic                             comma_seen;
  logic                             line_start;
  logic [drgb_pkg::CountWidth-1:0]  digits_seen;
  logic [drgb_pkg::ValueWidth-1:0]  chan_val [drgb_pkg::NumFields];
  logic [drgb_pkg::FieldWidth-1:0]  long_field;
  logic                             bad_seen;
  logic [drgb_pkg::CharWidth-1:0]   bad_char;
  logic [drgb_pkg::NumFields-1:0]   missing_fields;

  function automatic void clear_line_state();
    pos_field      = '0;
    in_number      = 1'b0;
    comma_seen     = 1'b0;
    line_start     = 1'b1;
    digits_seen    = '0;
    long_field     = drgb_pkg::FIELD_DONE;
    bad_seen       = 1'b0;
    bad_char       = '0;
    missing_fields = '0;
    for (int i = 0; i < drgb_pkg::NumFields; i++) chan_val[i] = '0;
  endfunction

  // a value ends: good means it ended on nul, comma or blank
  function automatic void close_value(input logic good);
    if (good) begin
      if (digits_seen > drgb_pkg::DIGITS_ADDED && long_field == drgb_pkg::FIELD_DONE)
        long_field = pos_field;
    end else begin
      missing_fields[pos_field] = 1'b1;
    end
    pos_field   = pos_field + 1'b1;
    in_number   = 1'b0;
    comma_seen  = 1'b0;
    digits_seen = '0;
  endfunction

  // advance the line state by one character; returns 1 when a result is due
  function automatic logic predict_char(input logic [drgb_pkg::CharWidth-1:0] c,
                                        output colour_result_t res);
    logic consumed;
    logic blank;
    logic digit;
    consumed = 1'b0;
    blank    = (c == drgb_pkg::CH_SPACE) || (c == drgb_pkg::CH_TAB);
    digit    = (c >= drgb_pkg::CH_ZERO) && (c <= drgb_pkg::CH_NINE);
    res      = '0;
    res.kind = drgb_pkg::ERR_NONE;

    // a character that ends a value is offered again to the next one
    while (!consumed && pos_field != drgb_pkg::FIELD_DONE) begin
      if (!in_number) begin
        if (blank) begin
          consumed = 1'b1;
        end else if (!comma_seen && c == drgb_pkg::CH_COMMA && !line_start) begin
          comma_seen = 1'b1;
          consumed   = 1'b1;
        end else if (digit) begin
          in_number           = 1'b1;
          digits_seen         = 3'd1;
          chan_val[pos_field] = drgb_pkg::ValueWidth'(c - drgb_pkg::CH_ZERO);
          consumed            = 1'b1;
        end else begin
          close_value(1'b0);
        end
      end else begin
        if (digit) begin
          // digits past the third only count toward the length
          if (digits_seen < drgb_pkg::DIGITS_ADDED)
            chan_val[pos_field] = drgb_pkg::ValueWidth'(chan_val[pos_field] * 10 +
                                                        (c - drgb_pkg::CH_ZERO));
          if (digits_seen < drgb_pkg::DIGITS_SAT) digits_seen = digits_seen + 1'b1;
          consumed = 1'b1;
        end else if (c == drgb_pkg::CH_NUL || c == drgb_pkg::CH_COMMA || blank) begin
          close_value(1'b1);
        end else begin
          close_value(1'b0);
        end
      end
    end

    // only the first leftover character is kept
    if (!consumed && c != drgb_pkg::CH_NUL && !bad_seen) begin
      bad_seen = 1'b1;
      bad_char = c;
    end
    line_start = 1'b0;

    if (c != drgb_pkg::CH_NUL) return 1'b0;

    if (long_field != drgb_pkg::FIELD_DONE) begin
      res.kind   = drgb_pkg::ERR_LONG;
      res.detail = drgb_pkg::ValueWidth'(long_field);
    end else if (bad_seen) begin
      res.kind   = drgb_pkg::ERR_CHAR;
      res.detail = drgb_pkg::ValueWidth'(bad_char);
    end else if (missing_fields != '0) begin
      res.kind   = drgb_pkg::ERR_MISSING;
      res.detail = missing_fields[0] ? 10'd0 : (missing_fields[1] ? 10'd1 : 10'd2);
    end else begin
      res.ok = 1'b1;
      // red, then green, then blue
      for (int i = 0; i < drgb_pkg::NumFields; i++) begin
        if (res.ok && chan_val[i] > drgb_pkg::CHANNEL_MAX) begin
          res.ok     = 1'b0;
          res.kind   = drgb_pkg::ERR_RANGE;
          res.detail = chan_val[i];
        end
      end
      if (res.ok) res.rgb = {chan_val[0][7:0], chan_val[1][7:0], chan_val[2][7:0]};
    end
    clear_line_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    errors++;
  endtask

  // offer one character; called and returning at a falling edge, valid left high
  task automatic send_char(input logic [drgb_pkg::CharWidth-1:0] c);
    colour_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      @(negedge clk);
    end
    chars.valid <= 1'b1;
    chars.ch    <= c;
    @(posedge clk);
    while (chars.ready !== 1'b1) @(posedge clk);
    // transaction taken at this edge
    chars_sent++;
    if (predict_char(c, res)) expected_colours.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_text[i]) send_char(line_text[i]);
  endtask

  // line text plus the closing nul
  task automatic send_text(input string s);
    line_text.delete();
    foreach (s[i]) line_text.push_back(s[i]);
    line_text.push_back(drgb_pkg::CH_NUL);
    send_line();
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    chars.valid <= 1'b0;
    do @(negedge clk); while (expected_colours.size() != 0);
  endtask

  task automatic push_blanks();
    repeat ($urandom_range(2))
      line_text.push_back($urandom_range(1) ? drgb_pkg::CH_SPACE : drgb_pkg::CH_TAB);
  endtask

  // mostly well-formed lines with random values, some noise and broken lines
  task automatic make_random_line();
    int unsigned r;
    int unsigned v;
    int unsigned pos;
    string       s;
    line_text.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 8))
        line_text.push_back(drgb_pkg::CharWidth'($urandom_range(1, 255)));
    end else begin
      for (int f = 0; f < drgb_pkg::NumFields; f++) begin
        push_blanks();
        // a comma at the very start of the line is rare and bad
        if ($urandom_range(99) < (f == 0 ? 5 : 60)) line_text.push_back(drgb_pkg::CH_COMMA);
        if ($urandom_range(99) < 3) line_text.push_back(drgb_pkg::CH_COMMA);
        push_blanks();
        r = $urandom_range(99);
        if (r >= 4 && r < 12) begin
          // value too long
          repeat ($urandom_range(4, 5))
            line_text.push_back(drgb_pkg::CH_ZERO + drgb_pkg::CharWidth'($urandom_range(9)));
        end else if (r >= 12) begin
          v = (r < 55) ? $urandom_range(255) : $urandom_range(999);
          s = $sformatf("%0d", v);
          if ($urandom_range(7) == 0)
            repeat (3 - s.len()) line_text.push_back(drgb_pkg::CH_ZERO);
          foreach (s[i]) line_text.push_back(s[i]);
        end
        // r below 4 leaves the value out
      end
      if ($urandom_range(99) < 10) push_blanks();
      if ($urandom_range(99) < 5)
        line_text.push_back(drgb_pkg::CharWidth'($urandom_range(1, 255)));
      if ($urandom_range(99) < 6) begin
        pos = $urandom_range(line_text.size());
        line_text.insert(pos, drgb_pkg::CharWidth'($urandom_range(1, 255)));
      end
    end
    line_text.push_back(drgb_pkg::CH_NUL);
  endtask

  // extremes and every error kind, no idling
  task automatic test_directed_lines();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_text("");              // empty line, first value missing
    send_text(",1 2 3");        // comma as first character
    send_text("255,0\t9");      // channel extremes, tab separator
    send_text("1,,2 3");        // doubled comma
    send_text("1 2 3 x");       // trailing character
    send_text("1 2");           // last value missing, nothing trailing
    send_text("1234 5 6");      // value too long
    send_text("256 300 999");   // red over range wins
    send_text("0 256 0");
    send_text("0 0 256");
    send_char(8'hff);           // all bits set, bad character
    send_char(drgb_pkg::CH_NUL);
    wait_drained();
  endtask

  task automatic test_random_lines(input int unsigned budget, input int unsigned sidle,
                                   input int unsigned ridle);
    int unsigned start;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start         = chars_sent;
    while (chars_sent - start < budget) begin
      make_random_line();
      send_line();
      // now and then hold the line until every result is back
      if ($urandom_range(99) < 4) wait_drained();
    end
    wait_drained();
  endtask

  // receiver holds off while short lines keep coming, so the block stalls on a nul
  task automatic test_result_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    repeat (12)
      send_text($sformatf("%0d,%0d %0d", $urandom_range(255), $urandom_range(255),
                          $urandom_range(300)));
    wait_drained();
  endtask

  // result side ready, with random idling or a counted hold-off
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // check every result transaction against the oldest expectation
  always @(posedge clk) begin
    colour_result_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      if (expected_colours.size() == 0) begin
        report_mismatch("result with none expected, kind", int'(result.error_kind), 0);
      end else begin
        want = expected_colours.pop_front();
        lines_checked++;
        if (result.ok !== want.ok) report_mismatch("ok", int'(result.ok), int'(want.ok));
        if (result.rgb !== want.rgb) report_mismatch("rgb", int'(result.rgb), int'(want.rgb));
        if (result.error_kind !== want.kind)
          report_mismatch("error_kind", int'(result.error_kind), int'(want.kind));
        if (result.error_detail !== want.detail)
          report_mismatch("error_detail", int'(result.error_detail), int'(want.detail));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_colours.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    chars.valid <= 1'b0;
    chars.ch    <= drgb_pkg::CH_NUL;
    clear_line_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_lines();
    test_random_lines(420, 28, 61);
    test_result_hold_off();
    test_random_lines(420, 61, 28);
    test_random_lines(420, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d characters sent, %0d line results checked, %0d mismatches", chars_sent,
             lines_checked, errors);
    $display("covered every error kind, result stalls of %0d cycles and drained pauses",
             HOLD_CYCLES);
    if (errors == 0 && expected_colours.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/drgb_pkg.sv
hdl/drgb_char_if.sv
hdl/drgb_result_if.sv
hdl/decimal_rgb_triplet_parser.sv
tb/tb_decimal_rgb_triplet_parser.sv
